// File: hw/rtl/cft_pkg.sv
// ============================================================================
// cft_pkg
// Shared types, widths and codes for the capped file table.
// ============================================================================
package cft_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SIZE_W      = 31;
    localparam int TIME_W      = 31;
    localparam int TOTAL_W     = 35;
    localparam int CAP_W       = 36;
    localparam logic [CAP_W-1:0] CAP_RESET = 36'h8_0000_0000;

    typedef logic [1:0]         op_t;
    typedef logic [1:0]         kind_t;
    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [TIME_W-1:0]  time_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [CAP_W-1:0]   cap_t;

    localparam op_t OP_ADD  = 2'd0;
    localparam op_t OP_LIST = 2'd1;
    localparam op_t OP_TRIM = 2'd2;

    localparam kind_t KIND_EVICT  = 2'd0;
    localparam kind_t KIND_LIST   = 2'd1;
    localparam kind_t KIND_DONE   = 2'd2;
    localparam kind_t KIND_REJECT = 2'd3;

    // One stored table entry
    typedef struct packed {
        logic  valid;
        logic  mark;
        size_t size;
        time_t ftime;
    } entry_t;

    // Per-cycle command to the cell row
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_ROT,
        CMD_INS,
        CMD_DEL,
        CMD_MARK,
        CMD_CLR
    } cmd_t;

    typedef struct packed {
        cmd_t  cmd;
        logic  sel;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/cft_req_if.sv
// ============================================================================
// cft_req_if
// Request channel: op and entry fields with valid/ready.
// ============================================================================
interface cft_req_if;
    logic            valid;
    logic            ready;
    cft_pkg::op_t    op;
    cft_pkg::size_t  file_size;
    cft_pkg::time_t  file_time;

    modport source (output valid, op, file_size, file_time, input ready);
    modport sink   (input valid, op, file_size, file_time, output ready);
endinterface

// File: hw/rtl/cft_rsp_if.sv
// ============================================================================
// cft_rsp_if
// Result channel: one result word per handshake.
// ============================================================================
interface cft_rsp_if;
    logic            valid;
    logic            ready;
    cft_pkg::kind_t  kind;
    cft_pkg::size_t  out_size;
    cft_pkg::time_t  out_time;
    cft_pkg::total_t total_size;
    logic            last;

    modport source (output valid, kind, out_size, out_time, total_size, last, input ready);
    modport sink   (input valid, kind, out_size, out_time, total_size, last, output ready);
endinterface

// File: hw/rtl/cft_cfg_if.sv
// ============================================================================
// cft_cfg_if
// Configuration write channel for the capacity register.
// ============================================================================
interface cft_cfg_if;
    logic          valid;
    logic          ready;
    cft_pkg::cap_t data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/capped_file_table_evict_smallest.sv
// ============================================================================
// capped_file_table_evict_smallest
// Time-ordered file table in a row of cells with smallest-first trimming.
// ============================================================================
// Add: the request is taken in IDLE; its result word is registered from DISPATCH.
// List and trim: each listed or evicted word is found by a full rotation of the
// cell row that searches for the smallest entry and is emitted from PICK; the
// closing word comes from DISPATCH. One request is worked at a time, and a
// stalled result word holds the sequencer until it is taken.
// Reset empties the table, zeroes the total and loads capacity with 2^35.
module capped_file_table_evict_smallest (
    input  logic      clk,
    input  logic      rst_n,
    cft_req_if.sink   req,
    cft_rsp_if.source rsp,
    cft_cfg_if.sink   cfg
);
    import cft_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_PICK
    } state_t;

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    size_t            size_reg, size_next;
    time_t            time_reg, time_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] listed_reg, listed_next;
    total_t           total_reg, total_next;
    cap_t             cap_reg;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    size_t            best_size_reg, best_size_next;
    time_t            best_time_reg, best_time_next;
    logic             found_reg, found_next;

    logic             out_valid_reg, out_valid_next;
    kind_t            out_kind_reg, out_kind_next;
    size_t            out_size_reg, out_size_next;
    time_t            out_time_reg, out_time_next;
    total_t           out_total_reg, out_total_next;
    logic             out_last_reg, out_last_next;

    cmd_t             cmd;
    logic             out_free;
    logic             emit;
    entry_t           cells   [MAX_ENTRIES];
    logic             chain   [MAX_ENTRIES+1];
    entry_t           tail_in;
    entry_t           empty_entry;

    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign empty_entry = '0;
    // wrap cell 0 around on rotation, shift an empty slot in on delete
    assign tail_in = (cmd == CMD_ROT) ? cells[0] : empty_entry;
    assign chain[0] = 1'b0;

    // cell row
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        assign ctrl.cmd = cmd;
        assign ctrl.sel = (best_idx_reg == IDX_W'(i));
        cft_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .chain_in    (chain[i]),
            .chain_out   (chain[i+1]),
            .left_entry  ((i == 0) ? empty_entry : cells[(i == 0) ? 0 : i-1]),
            .right_entry ((i == MAX_ENTRIES-1) ? tail_in
                                               : cells[(i == MAX_ENTRIES-1) ? i : i+1]),
            .new_size    (size_reg),
            .new_time    (time_reg),
            .entry       (cells[i])
        );
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        time_next      = time_reg;
        count_next     = count_reg;
        listed_next    = listed_reg;
        total_next     = total_reg;
        scan_next      = scan_reg;
        best_idx_next  = best_idx_reg;
        best_size_next = best_size_reg;
        best_time_next = best_time_reg;
        found_next     = found_reg;
        out_kind_next  = out_kind_reg;
        out_size_next  = out_size_reg;
        out_time_next  = out_time_reg;
        out_total_next = out_total_reg;
        out_last_next  = out_last_reg;
        cmd            = CMD_HOLD;
        emit           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.op;
                    size_next   = req.file_size;
                    time_next   = req.file_time;
                    listed_next = '0;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (out_free)
                begin
                    out_size_next = '0;
                    out_time_next = '0;
                    out_last_next = 1'b1;
                    out_kind_next = KIND_DONE;
                    out_total_next = total_reg;
                    state_next    = S_IDLE;
                    emit          = 1'b1;
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (count_reg == CNT_W'(MAX_ENTRIES))
                            begin
                                out_kind_next = KIND_REJECT;
                            end
                            else
                            begin
                                cmd            = CMD_INS;
                                count_next     = count_reg + 1'b1;
                                total_next     = total_reg + TOTAL_W'(size_reg);
                                out_total_next = total_next;
                            end
                        end
                        OP_LIST:
                        begin
                            if (listed_reg < count_reg)
                            begin
                                emit       = 1'b0;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                cmd = CMD_CLR;
                            end
                        end
                        OP_TRIM:
                        begin
                            if ((CAP_W'(total_reg) > cap_reg) && (count_reg != '0))
                            begin
                                emit       = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            out_kind_next = KIND_DONE;
                        end
                    endcase
                    if (state_next == S_SCAN)
                    begin
                        scan_next  = '0;
                        found_next = 1'b0;
                    end
                end
            end
            S_SCAN:
            begin
                // look at cell 0 while the row rotates back to alignment
                cmd = CMD_ROT;
                if (cells[0].valid && !cells[0].mark
                    && (!found_reg || (cells[0].size < best_size_reg)))
                begin
                    found_next     = 1'b1;
                    best_idx_next  = scan_reg;
                    best_size_next = cells[0].size;
                    best_time_next = cells[0].ftime;
                end
                scan_next = scan_reg + 1'b1;
                if (scan_reg == IDX_W'(MAX_ENTRIES-1))
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    out_size_next = best_size_reg;
                    out_time_next = best_time_reg;
                    out_last_next = 1'b0;
                    if (op_reg == OP_TRIM)
                    begin
                        cmd           = CMD_DEL;
                        out_kind_next = KIND_EVICT;
                        count_next    = count_reg - 1'b1;
                        total_next    = total_reg - TOTAL_W'(best_size_reg);
                    end
                    else
                    begin
                        cmd           = CMD_MARK;
                        out_kind_next = KIND_LIST;
                        listed_next   = listed_reg + 1'b1;
                    end
                    out_total_next = total_next;
                    state_next     = S_DISPATCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = emit || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                cap_reg <= cfg.data;
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        size_reg      <= size_next;
        time_reg      <= time_next;
        listed_reg    <= listed_next;
        scan_reg      <= scan_next;
        best_idx_reg  <= best_idx_next;
        best_size_reg <= best_size_next;
        best_time_reg <= best_time_next;
        found_reg     <= found_next;
        out_kind_reg  <= out_kind_next;
        out_size_reg  <= out_size_next;
        out_time_reg  <= out_time_next;
        out_total_reg <= out_total_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.kind       = out_kind_reg;
    assign rsp.out_size   = out_size_reg;
    assign rsp.out_time   = out_time_reg;
    assign rsp.total_size = out_total_reg;
    assign rsp.last       = out_last_reg;

endmodule

// File: hw/rtl/cft_cell.sv
// ============================================================================
// cft_cell
// One table slot: rotates, inserts and deletes with its neighbors, and sets or clears its mark.
// ============================================================================
module cft_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  cft_pkg::cell_ctrl_t ctrl,
    input  logic                chain_in,
    output logic                chain_out,
    input  cft_pkg::entry_t     left_entry,
    input  cft_pkg::entry_t     right_entry,
    input  cft_pkg::size_t      new_size,
    input  cft_pkg::time_t      new_time,
    output cft_pkg::entry_t     entry
);
    import cft_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   take;
    logic   del;

    // insert point: first slot empty or later than the new word
    assign take = !entry_reg.valid || (entry_reg.ftime > new_time);
    assign del  = ctrl.sel || chain_in;

    always_comb
    begin
        entry_next = entry_reg;
        chain_out  = 1'b0;
        case (ctrl.cmd)
            CMD_ROT:
            begin
                entry_next = right_entry;
            end
            CMD_INS:
            begin
                chain_out = take;
                if (chain_in)
                begin
                    entry_next = left_entry;
                end
                else if (take)
                begin
                    entry_next.valid = 1'b1;
                    entry_next.mark  = 1'b0;
                    entry_next.size  = new_size;
                    entry_next.ftime = new_time;
                end
            end
            CMD_DEL:
            begin
                chain_out = del;
                if (del)
                begin
                    entry_next = right_entry;
                end
            end
            CMD_MARK:
            begin
                if (ctrl.sel)
                begin
                    entry_next.mark = 1'b1;
                end
            end
            CMD_CLR:
            begin
                entry_next.mark = 1'b0;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // clear the slot under reset, else advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule
